[hdl/tgbc_pkg.sv]
package tgbc_pkg;

    // grid storage
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int FIX_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS);
    localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int LIM_W    = $clog2(MAX_DIM + 1);

    // field widths
    localparam int POS_W  = 12;
    localparam int SIZE_W = 9;
    localparam int Y_W    = 14;
    localparam int KIND_W = 4;
    localparam int TS_W   = 7;
    localparam int MAP_W  = 7;
    localparam int SNAP_W = 8;
    localparam int CFG_W  = 8;
    localparam int CIDX_W = 2;

    // divider: numerator is an edge coordinate, up to pos + size - 1
    localparam int QW     = POS_W + 1;
    localparam int DCNT_W = $clog2(QW);
    localparam int TOP_W  = QW + TS_W;
    localparam int SW     = TOP_W + 2;

    localparam logic signed [Y_W-1:0] Y_MIN = -(2 ** (Y_W - 1));
    localparam logic signed [Y_W-1:0] Y_MAX = (2 ** (Y_W - 1)) - 1;

    // request codes
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_LEFT  = 3'd1;
    localparam logic [2:0] REQ_RIGHT = 3'd2;
    localparam logic [2:0] REQ_DOWN  = 3'd3;
    localparam logic [2:0] REQ_UP    = 3'd4;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_TILE_SIZE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SNAP_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic wr_en;
        logic div_step;
        logic setup;
        logic rd_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_more;
        logic out_free;
    } sts_t;

endpackage

[hdl/tile_grid_box_collision_core.sv]
// Tile grid box collision core.
// Input channel (in_valid/in_ready): one word per request. Code 0 stores
// tile_kind at tile_col/tile_row; codes 1..4 test a box (pos/size) moving
// left, right, down or up against the grid. Output channel
// (out_valid/out_ready): exactly one result word per input word, in order.
// Register port (cfg_we/cfg_index/cfg_wdata): tile size, map width, map
// height and snap limit; write only while the core is idle.
// One word is in flight at a time; in_ready is high while idle.
// Load: the tile is written in the load state, then the result is loaded.
// Query: a 13-step restoring divide (four lanes in step) turns pixel edges
// into tile indices, then the grid RAM is read one tile per cycle over the
// N in-map tiles on the leading edge (0..64).
// Unused request codes go straight to the finish state.
// Reset restores the register defaults; the grid is not cleared and a tile
// reads as undefined until it has been loaded.
// If the receiver stalls, the finished result sits in the output register;
// the next word is still accepted and worked on, and waits at its final
// step until the held result is taken.
module tile_grid_box_collision_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // register port
    input  logic                                  cfg_we,
    input  logic [tgbc_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [tgbc_pkg::CFG_W-1:0]            cfg_wdata,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [2:0]                            req_type,
    input  logic [tgbc_pkg::POS_W-1:0]            pos_x,
    input  logic [tgbc_pkg::POS_W-1:0]            pos_y,
    input  logic [tgbc_pkg::SIZE_W-1:0]           size_x,
    input  logic [tgbc_pkg::SIZE_W-1:0]           size_y,
    input  logic signed [tgbc_pkg::Y_W-1:0]       ref_y,
    input  logic [5:0]                            tile_col,
    input  logic [5:0]                            tile_row,
    input  logic [tgbc_pkg::KIND_W-1:0]           tile_kind,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic signed [tgbc_pkg::Y_W-1:0]       new_y,
    output logic                                  y_changed,
    output logic                                  out_of_map
);

    // command and status between sequencer and datapath
    tgbc_pkg::cmd_t cmd;
    tgbc_pkg::sts_t sts;

    // sequencer: idle / load / divide / setup / scan / drain / finish
    tgbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: registers, divider lanes, grid RAM, snap logic, result register
    tgbc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .size_x     (size_x),
        .size_y     (size_y),
        .ref_y      (ref_y),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .tile_kind  (tile_kind),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .new_y      (new_y),
        .y_changed  (y_changed),
        .out_of_map (out_of_map),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

[hdl/tgbc_ctrl.sv]
module tgbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          req_type,
    output logic                in_ready,
    input  tgbc_pkg::sts_t      sts,
    output tgbc_pkg::cmd_t      cmd
);

    tgbc_pkg::state_t state_reg;
    tgbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgbc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tgbc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == tgbc_pkg::REQ_LOAD)
                    begin
                        state_next = tgbc_pkg::ST_LOAD;
                    end
                    else if (req_type == tgbc_pkg::REQ_LEFT || req_type == tgbc_pkg::REQ_RIGHT
                             || req_type == tgbc_pkg::REQ_DOWN || req_type == tgbc_pkg::REQ_UP)
                    begin
                        state_next = tgbc_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = tgbc_pkg::ST_FIN;
                    end
                end
            end
            tgbc_pkg::ST_LOAD:  state_next = tgbc_pkg::ST_FIN;
            tgbc_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = tgbc_pkg::ST_SETUP;
                end
            end
            tgbc_pkg::ST_SETUP: state_next = tgbc_pkg::ST_SCAN;
            tgbc_pkg::ST_SCAN:
            begin
                if (!sts.scan_more)
                begin
                    state_next = tgbc_pkg::ST_DRAIN;
                end
            end
            tgbc_pkg::ST_DRAIN: state_next = tgbc_pkg::ST_FIN;
            tgbc_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = tgbc_pkg::ST_IDLE;
                end
            end
            default:            state_next = tgbc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            tgbc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            tgbc_pkg::ST_LOAD:  cmd.wr_en    = 1'b1;
            tgbc_pkg::ST_DIV:   cmd.div_step = 1'b1;
            tgbc_pkg::ST_SETUP: cmd.setup    = 1'b1;
            tgbc_pkg::ST_SCAN:  cmd.rd_en    = sts.scan_more;
            tgbc_pkg::ST_DRAIN: cmd          = '0;
            tgbc_pkg::ST_FIN:   cmd.out_load = sts.out_free;
            default:            cmd          = '0;
        endcase
    end

endmodule

[hdl/tgbc_dp.sv]
module tgbc_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // register writes
    input  logic                                  cfg_we,
    input  logic [tgbc_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [tgbc_pkg::CFG_W-1:0]            cfg_wdata,
    // input word
    input  logic [2:0]                            req_type,
    input  logic [tgbc_pkg::POS_W-1:0]            pos_x,
    input  logic [tgbc_pkg::POS_W-1:0]            pos_y,
    input  logic [tgbc_pkg::SIZE_W-1:0]           size_x,
    input  logic [tgbc_pkg::SIZE_W-1:0]           size_y,
    input  logic signed [tgbc_pkg::Y_W-1:0]       ref_y,
    input  logic [5:0]                            tile_col,
    input  logic [5:0]                            tile_row,
    input  logic [tgbc_pkg::KIND_W-1:0]           tile_kind,
    // result word
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic signed [tgbc_pkg::Y_W-1:0]       new_y,
    output logic                                  y_changed,
    output logic                                  out_of_map,
    // controller link
    input  tgbc_pkg::cmd_t                        cmd,
    output tgbc_pkg::sts_t                        sts
);

    localparam int QW    = tgbc_pkg::QW;
    localparam int LIM_W = tgbc_pkg::LIM_W;
    localparam int SW    = tgbc_pkg::SW;

    // configuration
    logic [tgbc_pkg::TS_W-1:0]   ts_reg;
    logic [tgbc_pkg::MAP_W-1:0]  mw_reg;
    logic [tgbc_pkg::MAP_W-1:0]  mh_reg;
    logic [tgbc_pkg::SNAP_W-1:0] snap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg   <= tgbc_pkg::TS_W'(16);
            mw_reg   <= tgbc_pkg::MAP_W'(64);
            mh_reg   <= tgbc_pkg::MAP_W'(64);
            snap_reg <= tgbc_pkg::SNAP_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tgbc_pkg::CFG_TILE_SIZE:  ts_reg   <= cfg_wdata[tgbc_pkg::TS_W-1:0];
                tgbc_pkg::CFG_MAP_WIDTH:  mw_reg   <= cfg_wdata[tgbc_pkg::MAP_W-1:0];
                tgbc_pkg::CFG_MAP_HEIGHT: mh_reg   <= cfg_wdata[tgbc_pkg::MAP_W-1:0];
                tgbc_pkg::CFG_SNAP_LIMIT: snap_reg <= cfg_wdata[tgbc_pkg::SNAP_W-1:0];
                default:                  snap_reg <= snap_reg;
            endcase
        end
    end

    logic [tgbc_pkg::TS_W-1:0] ts_eff;
    logic [LIM_W-1:0]          w_eff;
    logic [LIM_W-1:0]          h_eff;

    assign ts_eff = (ts_reg == '0) ? tgbc_pkg::TS_W'(1) : ts_reg;
    assign w_eff  = (LIM_W'(mw_reg) > LIM_W'(tgbc_pkg::MAX_COLS))
                    ? LIM_W'(tgbc_pkg::MAX_COLS) : LIM_W'(mw_reg);
    assign h_eff  = (LIM_W'(mh_reg) > LIM_W'(tgbc_pkg::MAX_ROWS))
                    ? LIM_W'(tgbc_pkg::MAX_ROWS) : LIM_W'(mh_reg);

    // latched word
    logic [2:0]                       req_reg;
    logic signed [tgbc_pkg::Y_W-1:0]  ry_reg;
    logic [tgbc_pkg::SIZE_W-1:0]      sy_reg;
    logic [5:0]                       tc_reg;
    logic [5:0]                       tr_reg;
    logic [tgbc_pkg::KIND_W-1:0]      tk_reg;

    logic [tgbc_pkg::SIZE_W-1:0] sx_eff;
    logic [tgbc_pkg::SIZE_W-1:0] sy_eff;
    logic                        load_in_map;

    assign sx_eff      = (size_x == '0) ? tgbc_pkg::SIZE_W'(1) : size_x;
    assign sy_eff      = (size_y == '0) ? tgbc_pkg::SIZE_W'(1) : size_y;
    assign load_in_map = (32'(tile_col) < tgbc_pkg::MAX_COLS)
                         && (32'(tile_row) < tgbc_pkg::MAX_ROWS);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            ry_reg  <= ref_y;
            sy_reg  <= sy_eff;
            tc_reg  <= tile_col;
            tr_reg  <= tile_row;
            tk_reg  <= tile_kind;
        end
    end

    // four restoring divider lanes: x0, x1, y0, y1
    logic [QW-1:0]               num_reg  [4];
    logic [QW-1:0]               q_reg    [4];
    logic [tgbc_pkg::TS_W-1:0]   rem_reg  [4];
    logic [tgbc_pkg::DCNT_W-1:0] dcnt_reg;
    logic [QW-1:0]               num_init [4];

    assign num_init[0] = QW'(pos_x);
    assign num_init[1] = QW'(pos_x) + QW'(sx_eff) - QW'(1);
    assign num_init[2] = QW'(pos_y);
    assign num_init[3] = QW'(pos_y) + QW'(sy_eff) - QW'(1);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [tgbc_pkg::TS_W:0] rsh;
            logic                    ge;
            rsh = {rem_reg[i], num_reg[i][QW-1]};
            ge  = (rsh >= {1'b0, ts_eff});
            if (cmd.capture)
            begin
                num_reg[i] <= num_init[i];
                rem_reg[i] <= '0;
                q_reg[i]   <= '0;
            end
            else if (cmd.div_step)
            begin
                num_reg[i] <= {num_reg[i][QW-2:0], 1'b0};
                rem_reg[i] <= ge ? tgbc_pkg::TS_W'(rsh - {1'b0, ts_eff})
                                 : tgbc_pkg::TS_W'(rsh);
                q_reg[i]   <= {q_reg[i][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + tgbc_pkg::DCNT_W'(1);
        end
    end

    assign sts.div_done = (dcnt_reg == tgbc_pkg::DCNT_W'(QW - 1));

    // scan setup
    logic                    col_mode;
    logic [QW-1:0]           fixed_q;
    logic [QW-1:0]           start_q;
    logic [QW-1:0]           stop_q;
    logic [LIM_W-1:0]        fixed_lim;
    logic [LIM_W-1:0]        run_lim;
    logic                    fixed_out;
    logic                    stop_out;

    always_comb
    begin
        col_mode  = (req_reg == tgbc_pkg::REQ_LEFT) || (req_reg == tgbc_pkg::REQ_RIGHT);
        fixed_q   = (req_reg == tgbc_pkg::REQ_LEFT)  ? q_reg[0] :
                    (req_reg == tgbc_pkg::REQ_RIGHT) ? q_reg[1] :
                    (req_reg == tgbc_pkg::REQ_DOWN)  ? q_reg[3] : q_reg[2];
        start_q   = col_mode ? q_reg[2] : q_reg[0];
        stop_q    = col_mode ? q_reg[3] : q_reg[1];
        fixed_lim = col_mode ? w_eff : h_eff;
        run_lim   = col_mode ? h_eff : w_eff;
        fixed_out = (fixed_q >= QW'(fixed_lim));
        stop_out  = (stop_q >= QW'(run_lim));
    end

    logic                        colm_reg;
    logic                        skip_reg;
    logic [tgbc_pkg::FIX_W-1:0]  fix_reg;
    logic [QW-1:0]               idx_reg;
    logic [LIM_W-1:0]            end_reg;
    logic [tgbc_pkg::TOP_W-1:0]  top_reg;
    logic                        oom_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            oom_reg <= (req_type == tgbc_pkg::REQ_LOAD) && !load_in_map;
        end
        else if (cmd.setup)
        begin
            colm_reg <= col_mode;
            skip_reg <= fixed_out;
            fix_reg  <= fixed_q[tgbc_pkg::FIX_W-1:0];
            idx_reg  <= start_q;
            end_reg  <= stop_out ? run_lim : LIM_W'(stop_q + QW'(1));
            top_reg  <= tgbc_pkg::TOP_W'(ts_eff) * tgbc_pkg::TOP_W'(q_reg[3]);
            oom_reg  <= fixed_out || stop_out;
        end
        else if (cmd.rd_en)
        begin
            idx_reg <= idx_reg + QW'(1);
        end
    end

    assign sts.scan_more = !skip_reg && (idx_reg < QW'(end_reg));

    // tile store
    logic [tgbc_pkg::KIND_W-1:0] mem [tgbc_pkg::MAX_COLS * tgbc_pkg::MAX_ROWS];
    logic [tgbc_pkg::KIND_W-1:0] rdata_reg;
    logic [tgbc_pkg::ADDR_W-1:0] waddr;
    logic [tgbc_pkg::ADDR_W-1:0] raddr;
    logic [tgbc_pkg::ROW_W-1:0]  row_sel;
    logic [tgbc_pkg::COL_W-1:0]  col_sel;

    assign row_sel = colm_reg ? idx_reg[tgbc_pkg::ROW_W-1:0] : fix_reg[tgbc_pkg::ROW_W-1:0];
    assign col_sel = colm_reg ? fix_reg[tgbc_pkg::COL_W-1:0] : idx_reg[tgbc_pkg::COL_W-1:0];
    assign raddr   = tgbc_pkg::ADDR_W'(row_sel) * tgbc_pkg::ADDR_W'(tgbc_pkg::MAX_COLS)
                     + tgbc_pkg::ADDR_W'(col_sel);
    assign waddr   = tgbc_pkg::ADDR_W'(tr_reg) * tgbc_pkg::ADDR_W'(tgbc_pkg::MAX_COLS)
                     + tgbc_pkg::ADDR_W'(tc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !oom_reg)
        begin
            mem[waddr] <= tk_reg;
        end
        rdata_reg <= mem[raddr];
    end

    logic pend_reg;
    logic found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.rd_en;
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (pend_reg && (rdata_reg != '0))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // snap test and result
    logic signed [SW-1:0]           ry_s;
    logic signed [SW-1:0]           top_s;
    logic signed [SW-1:0]           sy_s;
    logic signed [SW-1:0]           over;
    logic signed [SW-1:0]           ny_full;
    logic                           snap_ok;
    logic signed [tgbc_pkg::Y_W-1:0] ny_sat;

    always_comb
    begin
        ry_s    = SW'(ry_reg);
        top_s   = $signed({2'b00, top_reg});
        sy_s    = $signed(SW'(sy_reg));
        over    = ry_s - top_s + sy_s;
        ny_full = top_s - sy_s;
        snap_ok = (over <= $signed(SW'(snap_reg)));
        if (ny_full > SW'(tgbc_pkg::Y_MAX))
        begin
            ny_sat = tgbc_pkg::Y_MAX;
        end
        else if (ny_full < SW'(tgbc_pkg::Y_MIN))
        begin
            ny_sat = tgbc_pkg::Y_MIN;
        end
        else
        begin
            ny_sat = ny_full[tgbc_pkg::Y_W-1:0];
        end
    end

    logic                           out_valid_reg;
    logic                           hit_reg;
    logic signed [tgbc_pkg::Y_W-1:0] ny_reg;
    logic                           chg_reg;
    logic                           oomo_reg;
    logic                           is_query;
    logic                           down_snap;

    assign is_query  = (req_reg == tgbc_pkg::REQ_LEFT) || (req_reg == tgbc_pkg::REQ_RIGHT)
                       || (req_reg == tgbc_pkg::REQ_DOWN) || (req_reg == tgbc_pkg::REQ_UP);
    assign down_snap = (req_reg == tgbc_pkg::REQ_DOWN) && found_reg && snap_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hit_reg  <= (req_reg == tgbc_pkg::REQ_DOWN) ? down_snap
                                                        : (is_query && found_reg);
            ny_reg   <= down_snap ? ny_sat : ry_reg;
            chg_reg  <= down_snap;
            oomo_reg <= (is_query || (req_reg == tgbc_pkg::REQ_LOAD)) && oom_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign new_y        = ny_reg;
    assign y_changed    = chg_reg;
    assign out_of_map   = oomo_reg;

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (!skip_reg && (idx_reg < QW'(end_reg))))
        else $error("tile read issued outside the scan window");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

    a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (!found_reg && !pend_reg))
        else $error("hit accumulator not cleared for new word");

    a_snap_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (!y_changed || hit))
        else $error("y snapped without a hit");

endmodule
